// ===== src/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants of the parabolic peak finder
// Register indexes, result field widths, queue sizing, divider steps and back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_EDGES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE_MODE = 1'd1;

  // Result fields
  localparam int POS_W     = 24;
  localparam int HEIGHT_W  = 25;
  localparam int M_TDATA_W = ((POS_W + HEIGHT_W + 7) / 8) * 8;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LDIV,
    ST_DIV,
    ST_FIN
  } back_state_e;

endpackage

// ===== src/pfp_front.sv =====
// ----------------------------------------------------------------------------
// pfp_front: sample intake and peak classification
// Keeps the last two samples and the frame index, detects edge and interior
// peaks and pushes one job per peak into the queue, in frame order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfp_front import pfp_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16,
  localparam int JOB_W      = INDEX_BITS + 3 * SAMPLE_BITS + 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] s_sample_i,
  input  logic                          s_last_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [JOB_W-1:0]              push_data_o
);

  typedef struct packed {
    logic                          interp;
    logic                          last;
    logic [INDEX_BITS-1:0]         idx;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          neg;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SAMPLE_BITS:0]          d2;
  } job_t;

  logic                          incl_edges_q;
  logic                          interp_q;
  logic signed [SAMPLE_BITS-1:0] older_q;
  logic signed [SAMPLE_BITS-1:0] newer_q;
  logic [INDEX_BITS-1:0]         idx_q;
  logic                          pend_q;
  job_t                          pend_job_q;

  logic                          accept;
  logic [INDEX_BITS-1:0]         idx_inc;
  logic signed [SAMPLE_BITS:0]   rise;
  logic signed [SAMPLE_BITS:0]   fall;
  logic signed [SAMPLE_BITS:0]   diff;
  logic                          is_edge_first;
  logic                          is_inner;
  logic                          is_edge_last;
  logic                          hit0;
  logic                          hit1;
  job_t                          job0;
  job_t                          job1;

  assign accept    = s_valid_i && s_ready_o;
  assign s_ready_o = !pend_q && push_ready_i;

  // Saturating 1-based index of the incoming sample
  assign idx_inc = (idx_q == '1) ? idx_q : idx_q + 1'b1;

  // Slopes around the middle sample
  assign rise = (SAMPLE_BITS+1)'(newer_q) - (SAMPLE_BITS+1)'(older_q);
  assign fall = (SAMPLE_BITS+1)'(newer_q) - (SAMPLE_BITS+1)'(s_sample_i);
  assign diff = (SAMPLE_BITS+1)'(s_sample_i) - (SAMPLE_BITS+1)'(older_q);

  // Peak classification
  assign is_edge_first = (idx_inc == INDEX_BITS'(2)) && incl_edges_q && (newer_q > s_sample_i);
  assign is_inner      = (idx_inc >= INDEX_BITS'(3)) && (newer_q > older_q)
                         && (newer_q >= s_sample_i);
  assign is_edge_last  = s_last_i && (idx_inc >= INDEX_BITS'(2)) && incl_edges_q
                         && (s_sample_i > newer_q);
  assign hit0 = is_edge_first || is_inner;
  assign hit1 = is_edge_last;

  // Job records: first slot is the left edge or an interior peak, second the right edge
  always_comb begin
    job0        = '0;
    job0.interp = is_inner && interp_q;
    job0.last   = !hit1;
    job0.idx    = is_inner ? idx_inc - 1'b1 : INDEX_BITS'(1);
    job0.y      = newer_q;
    job0.neg    = diff[SAMPLE_BITS];
    job0.mag    = SAMPLE_BITS'(diff[SAMPLE_BITS] ? -diff : diff);
    job0.d2     = $unsigned(rise + fall);

    job1        = '0;
    job1.interp = 1'b0;
    job1.last   = 1'b1;
    job1.idx    = idx_inc;
    job1.y      = s_sample_i;
  end

  // Queue push: a held second job goes first
  assign push_valid_o = pend_q || (accept && (hit0 || hit1));
  assign push_data_o  = pend_q ? pend_job_q : (hit0 ? job0 : job1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_edges_q <= 1'b0;
      interp_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INCLUDE_EDGES:    incl_edges_q <= cfg_data_i[0];
        REG_INTERPOLATE_MODE: interp_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sample history and frame index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      idx_q   <= '0;
    end else if (accept) begin
      older_q <= newer_q;
      newer_q <= s_sample_i;
      idx_q   <= s_last_i ? '0 : idx_inc;
    end
  end

  // Second job of a beat waits here for the next queue slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept && hit0 && hit1) begin
      pend_q <= 1'b1;
    end else if (pend_q && push_ready_i) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit0 && hit1) begin
      pend_job_q <= job1;
    end
  end

  // Checks
  a_edge_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(is_edge_first && is_inner))
    else $error("left edge and interior peak on one beat");

  a_pend_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hit0 && hit1) |=> (pend_q && push_valid_o))
    else $error("second job of a beat was not held");

  a_frame_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_last_i) |=> (idx_q == '0))
    else $error("frame index not cleared after last beat");

endmodule

// ===== src/pfp_queue.sv =====
// ----------------------------------------------------------------------------
// pfp_queue: small job FIFO between front and back
// Lets classification run ahead while the back end works on a division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfp_queue import pfp_pkg::*; #(
  parameter int WIDTH = 68
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready_o = (count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/pfp_div.sv =====
// ----------------------------------------------------------------------------
// pfp_div: iterative unsigned divider
// Restoring division, DIV_STEPS quotient bits per cycle. The caller makes
// sure the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfp_div import pfp_pkg::*; #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 18,
  parameter int QUO_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CYC   = QUO_W / DIV_STEPS;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] nq_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_d;
  logic [QUO_W-1:0] nq_d;
  logic [DEN_W:0]   shifted;
  logic             qbit;

  assign busy_o = (cnt_q != '0);
  assign quo_o  = nq_q;

  // Combinational compare-subtract steps, DIV_STEPS in a row
  always_comb begin
    rem_d   = rem_q;
    nq_d    = nq_q;
    shifted = '0;
    qbit    = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      shifted = {rem_d, nq_d[QUO_W-1]};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DEN_W'(shifted - {1'b0, den_q});
        qbit  = 1'b1;
      end else begin
        rem_d = shifted[DEN_W-1:0];
        qbit  = 1'b0;
      end
      nq_d = {nq_d[QUO_W-2:0], qbit};
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(CYC);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Partial remainder, numerator bits shifting out, quotient bits shifting in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DEN_W'(num_i >> QUO_W);
      nq_q  <= num_i[QUO_W-1:0];
    end else if (busy_o) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
    end
  end

endmodule

// ===== src/pfp_back.sv =====
// ----------------------------------------------------------------------------
// pfp_back: peak evaluation and result register
// Plain jobs go straight to the output. Interpolated jobs square the slope
// difference, then run the position and height divisions side by side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfp_back import pfp_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16,
  parameter int FRAC_BITS   = 8,
  localparam int JOB_W      = INDEX_BITS + 3 * SAMPLE_BITS + 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  logic [JOB_W-1:0]           pop_data_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [POS_W-1:0]           m_pos_o,
  output logic signed [HEIGHT_W-1:0] m_height_o,
  output logic                       m_last_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int N1_W = SB + FRAC_BITS + 2;
  localparam int D1_W = SB + 2;
  localparam int Q1_W = ((FRAC_BITS + 1 + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int N2_W = 2 * SB + FRAC_BITS + 1;
  localparam int D2_W = SB + 4;
  localparam int Q2_W = ((SB + FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int PX   = (INDEX_BITS + FRAC_BITS + 2 > POS_W + 2) ?
                        INDEX_BITS + FRAC_BITS + 2 : POS_W + 2;
  localparam int HX   = (SB + FRAC_BITS + 3 > HEIGHT_W + 1) ?
                        SB + FRAC_BITS + 3 : HEIGHT_W + 1;

  typedef struct packed {
    logic                          interp;
    logic                          last;
    logic [INDEX_BITS-1:0]         idx;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          neg;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SAMPLE_BITS:0]          d2;
  } job_t;

  back_state_e                state_q;
  back_state_e                state_d;
  job_t                       job_q;
  logic [2*SB-1:0]            sq_q;
  logic                       m_valid_q;
  logic [POS_W-1:0]           pos_q;
  logic signed [HEIGHT_W-1:0] height_q;
  logic                       last_q;

  job_t                       head;
  job_t                       src;
  logic                       slot_free;
  logic                       div_start;
  logic                       load_out;
  logic [N1_W-1:0]            num1;
  logic [D1_W-1:0]            den1;
  logic [N2_W-1:0]            num2;
  logic [D2_W-1:0]            den2;
  logic                       div1_busy;
  logic                       div2_busy;
  logic [Q1_W-1:0]            quo1;
  logic [Q2_W-1:0]            quo2;
  logic [PX-1:0]              pos_base;
  logic [PX-1:0]              frac_x;
  logic signed [PX-1:0]       pos_s;
  logic [POS_W-1:0]           pos_sat;
  logic signed [HX-1:0]       y_x;
  logic [HX-1:0]              corr_x;
  logic signed [HX-1:0]       h_s;
  logic [HX-HEIGHT_W:0]       h_top;
  logic signed [HEIGHT_W-1:0] h_sat;

  assign head      = job_t'(pop_data_i);
  assign slot_free = !m_valid_q || m_ready_i;

  // Division operands
  assign num1 = (N1_W'(job_q.mag) << FRAC_BITS) + N1_W'(job_q.d2);
  assign den1 = {job_q.d2, 1'b0};
  assign num2 = (N2_W'(sq_q) << FRAC_BITS) + N2_W'({job_q.d2, 2'b00});
  assign den2 = {job_q.d2, 3'b000};

  pfp_div #(
    .NUM_W (N1_W),
    .DEN_W (D1_W),
    .QUO_W (Q1_W)
  ) u_div_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num1),
    .den_i   (den1),
    .busy_o  (div1_busy),
    .quo_o   (quo1)
  );

  pfp_div #(
    .NUM_W (N2_W),
    .DEN_W (D2_W),
    .QUO_W (Q2_W)
  ) u_div_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num2),
    .den_i   (den2),
    .busy_o  (div2_busy),
    .quo_o   (quo2)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && head.interp) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_LDIV;
      ST_LDIV: state_d = ST_DIV;
      ST_DIV: begin
        if (!div1_busy && !div2_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_ready_o = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = head.interp || slot_free;
        load_out    = pop_valid_i && !head.interp && slot_free;
      end
      ST_LDIV: div_start = 1'b1;
      ST_FIN:  load_out  = slot_free;
      default: ;
    endcase
  end

  // Result: plain jobs from the queue head, interpolated ones from the job register
  always_comb begin
    src      = (state_q == ST_FIN) ? job_q : head;
    pos_base = PX'(src.idx) << FRAC_BITS;
    frac_x   = (state_q == ST_FIN) ? PX'(quo1) : '0;
    corr_x   = (state_q == ST_FIN) ? HX'(quo2) : '0;
    pos_s    = (src.neg && (state_q == ST_FIN)) ? $signed(pos_base - frac_x)
                                                : $signed(pos_base + frac_x);
    if (pos_s[PX-1]) begin
      pos_sat = '0;
    end else if (|pos_s[PX-2:POS_W]) begin
      pos_sat = '1;
    end else begin
      pos_sat = pos_s[POS_W-1:0];
    end

    y_x   = HX'(src.y);
    h_s   = (y_x <<< FRAC_BITS) + $signed(corr_x);
    h_top = h_s[HX-1:HEIGHT_W-1];
    if ((&h_top) || !(|h_top)) begin
      h_sat = h_s[HEIGHT_W-1:0];
    end else if (h_s[HX-1]) begin
      h_sat = {1'b1, {(HEIGHT_W-1){1'b0}}};
    end else begin
      h_sat = {1'b0, {(HEIGHT_W-1){1'b1}}};
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Job capture and squared slope difference
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i && head.interp) begin
      job_q <= head;
    end
    if (state_q == ST_MUL) begin
      sq_q <= job_q.mag * job_q.mag;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pos_q    <= pos_sat;
      height_q <= h_sat;
      last_q   <= src.last;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_pos_o    = pos_q;
  assign m_height_o = height_q;
  assign m_last_o   = last_q;

  // Checks
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!div1_busy && !div2_busy))
    else $error("divider running while back end is idle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!m_valid_q || m_ready_i))
    else $error("result overwritten before it was taken");

  a_interp_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && pop_valid_i && head.interp) |=> (state_q == ST_MUL))
    else $error("interpolated job did not enter the multiply step");

endmodule

// ===== src/peak_finder_parabolic.sv =====
// ----------------------------------------------------------------------------
// peak_finder_parabolic: streaming local-maximum finder with parabolic fit
// A sample beat is taken every cycle while the job queue has room; a beat that
// yields two peaks holds the input until its second job is queued. Interior
// and left-edge peaks are found as the next sample arrives, right-edge ones
// with the last sample. Plain results pass the job queue and output register;
// interpolated ones also the multiply, load, divide and finish states, the
// height divider setting the divide length; no job is taken meanwhile. Reset
// restores include_edges 0, interpolate_mode 1, frame index 0, empty queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_finder_parabolic import pfp_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16,
  parameter int FRAC_BITS   = 8,
  localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Sample stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // sample
  input  logic                  s_axis_tlast,   // frame_last
  // Peak stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // peak_position, peak_height
  output logic                  m_axis_tlast    // run_last
);

  localparam int JOB_W = INDEX_BITS + 3 * SAMPLE_BITS + 4;

  logic                       push_valid;
  logic                       push_ready;
  logic [JOB_W-1:0]           push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  logic [JOB_W-1:0]           pop_data;
  logic [POS_W-1:0]           peak_pos;
  logic signed [HEIGHT_W-1:0] peak_height;

  pfp_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_sample_i   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .s_last_i     (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pfp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pfp_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_pos_o     (peak_pos),
    .m_height_o  (peak_height),
    .m_last_o    (m_axis_tlast)
  );

  // Output beat packing, position in the low bits
  assign m_axis_tdata = M_TDATA_W'({peak_height, peak_pos});

endmodule

// ===== bench/tb_peak_finder_parabolic.sv =====
// ----------------------------------------------------------------------------
// tb_peak_finder_parabolic: self-checking bench for the parabolic peak finder
// Streams frames of signed samples through the block, with a bursty sender and
// a stalling receiver, and predicts every peak beat in plain and interpolated
// mode, with and without edge peaks. Directed frames cover extremes, rounding
// ties and edge peaks; random frames follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peak_finder_parabolic;
  import pfp_pkg::*;

  localparam longint ONE_POS       = 64'd1 << 8;  // 1.0 in 8 fraction bits
  localparam longint POS_MAX       = (64'd1 << POS_W) - 1;
  localparam longint HEIGHT_MAX    = (64'd1 << (HEIGHT_W - 1)) - 1;
  localparam logic [15:0] IDX_MAX  = 16'hFFFF;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     RANDOM_ITEMS  = 265;

  typedef struct packed {
    logic signed [15:0] value;
    logic               frame_end;
  } sample_beat_t;

  typedef struct packed {
    logic        [POS_W-1:0]    position;
    logic signed [HEIGHT_W-1:0] height;
    logic                       run_last;
  } peak_t;

  // DUT ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // sample
  logic                  s_axis_tlast  = 1'b0; // frame_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // peak_position, peak_height
  logic                  m_axis_tlast;        // run_last

  // Stimulus and expectation stores
  sample_beat_t sample_q[$];
  peak_t        peak_q[$];
  int           beats_queued = 0;
  int           beats_sent   = 0;
  int           beats_taken  = 0;
  int           err_cnt      = 0;

  // Predictor state, mirrors the block after reset
  logic               edges_on  = 1'b0;
  logic               interp_on = 1'b1;
  logic signed [15:0] older_smp = '0;
  logic signed [15:0] newer_smp = '0;
  logic        [15:0] frame_idx = '0;

  peak_finder_parabolic i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Clamp to the result field widths
  function automatic peak_t make_peak(longint pos, longint hgt);
    peak_t pk;
    if (pos < 0) pos = 0;
    if (pos > POS_MAX) pos = POS_MAX;
    if (hgt > HEIGHT_MAX) hgt = HEIGHT_MAX;
    if (hgt < -HEIGHT_MAX - 1) hgt = -HEIGHT_MAX - 1;
    pk.position = pos[POS_W-1:0];
    pk.height   = hgt[HEIGHT_W-1:0];
    pk.run_last = 1'b0;
    return pk;
  endfunction

  // Peaks caused by one accepted sample, in frame order
  task automatic predict_peaks(logic signed [15:0] smp, logic frame_end);
    peak_t  found[$];
    longint n, nw, od, s, p, q, d2, diff, mag, scaled, frac, corr, pos;
    if (frame_idx != IDX_MAX) frame_idx++;
    n  = frame_idx;
    nw = newer_smp;
    od = older_smp;
    s  = smp;
    // first-sample edge peak
    if (n == 2 && edges_on && nw > s) found.push_back(make_peak(ONE_POS, nw * ONE_POS));
    // interior peak at the previous sample
    if (n >= 3 && nw > od && nw >= s) begin
      if (interp_on) begin
        p      = nw - od;
        q      = nw - s;
        d2     = p + q;
        diff   = s - od;
        mag    = (diff < 0) ? -diff : diff;
        scaled = mag * ONE_POS;
        // round to nearest, ties away from zero
        frac   = (2 * scaled + 2 * d2) / (4 * d2);
        corr   = (2 * mag * scaled + 8 * d2) / (16 * d2);
        pos    = (n - 1) * ONE_POS + ((diff < 0) ? -frac : frac);
        found.push_back(make_peak(pos, nw * ONE_POS + corr));
      end else begin
        found.push_back(make_peak((n - 1) * ONE_POS, nw * ONE_POS));
      end
    end
    if (frame_end) begin
      // last-sample edge peak
      if (n >= 2 && edges_on && s > nw) found.push_back(make_peak(n * ONE_POS, s * ONE_POS));
      frame_idx = '0;
    end
    older_smp = newer_smp;
    newer_smp = smp;
    if (found.size() > 0) found[found.size() - 1].run_last = 1'b1;
    foreach (found[k]) peak_q.push_back(found[k]);
  endtask

  // Accepted sample beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_peaks(s_axis_tdata, s_axis_tlast);
      beats_taken <= beats_taken + 1;
    end
  end

  // Sample driver: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin : sample_driver
    sample_beat_t cur;
    logic         nxt_valid;
    if (beats_taken == beats_sent) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (rst_ni && sample_q.size() > 0) begin
        cur = sample_q.pop_front();
        s_axis_tdata <= cur.value;
        s_axis_tlast <= cur.frame_end;
        nxt_valid    = 1'b1;
        beats_sent   <= beats_sent + 1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // Receiver stalls on a rotating ready pattern, reloaded now and then
  logic [7:0] rdy_pat = 8'hFF;
  int         rdy_cnt = 0;

  always @(negedge clk_i) begin : ready_pattern
    if (rdy_cnt == 0) begin
      case ($urandom_range(0, 3))
        0:       rdy_pat = 8'hFF;
        1:       rdy_pat = 8'h01;
        2:       rdy_pat = 8'h6D;
        default: rdy_pat = 8'($urandom);
      endcase
      if (rdy_pat == 8'h00) rdy_pat = 8'hFF;
      rdy_cnt = $urandom_range(16, 96);
    end
    rdy_cnt--;
    m_axis_tready <= rdy_pat[0];
    rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
  end

  // Peak monitor: compare each beat with the oldest expected peak
  always @(posedge clk_i) begin : peak_monitor
    peak_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.position = m_axis_tdata[POS_W-1:0];
      got.height   = m_axis_tdata[POS_W +: HEIGHT_W];
      got.run_last = m_axis_tlast;
      if (peak_q.size() == 0) begin
        $error("unexpected peak beat: position %0d, height %0d",
               got.position, $signed(got.height));
        err_cnt++;
      end else begin
        want = peak_q.pop_front();
        if (got.position !== want.position) begin
          $error("peak_position: expected %0d, got %0d", want.position, got.position);
          err_cnt++;
        end
        if (got.height !== want.height) begin
          $error("peak_height: expected %0d, got %0d",
                 $signed(want.height), $signed(got.height));
          err_cnt++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
          err_cnt++;
        end
      end
    end
  end

  task automatic add_beat(int v, logic frame_end);
    sample_beat_t b;
    b.value     = v[15:0];
    b.frame_end = frame_end;
    sample_q.push_back(b);
    beats_queued++;
  endtask

  // One frame of random length and shape
  task automatic add_random_frame();
    int len, shape, base, slope, period, ph, r, v;
    r      = $urandom_range(0, 19);
    len    = (r == 0) ? 1 : (r < 17) ? $urandom_range(2, 24) : $urandom_range(25, 80);
    shape  = $urandom_range(0, 3);
    base   = int'($urandom_range(0, 40000)) - 20000;
    slope  = $urandom_range(1, 2000);
    period = $urandom_range(3, 12);
    for (int j = 0; j < len; j++) begin
      case (shape)
        // full range
        0: v = $urandom;
        // small values: plateaus and ties
        1: v = int'($urandom_range(0, 6)) - 3;
        // triangle hills with a little noise
        2: begin
          ph = j % period;
          ph = (ph > period / 2) ? period - ph : ph;
          v  = base + slope * ph + int'($urandom_range(0, 6)) - 3;
        end
        // extremes
        default: begin
          case ($urandom_range(0, 4))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = 0;
            3:       v = -1;
            default: v = 1;
          endcase
        end
      endcase
      add_beat(v, j == len - 1);
    end
  endtask

  // Block idle: nothing queued, in flight or expected
  task automatic wait_idle();
    while (sample_q.size() != 0 || beats_taken != beats_sent || peak_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_INCLUDE_EDGES:    edges_on  = val[0];
      REG_INTERPOLATE_MODE: interp_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(logic edges, logic interp);
    int target;
    write_reg(REG_INCLUDE_EDGES, edges);
    write_reg(REG_INTERPOLATE_MODE, interp);
    target = beats_queued + RANDOM_ITEMS;
    while (beats_queued < target) add_random_frame();
    wait_idle();
  endtask

  // Timeout
  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames, edges on, interpolation on
    write_reg(REG_INCLUDE_EDGES, 1'b1);
    write_reg(REG_INTERPOLATE_MODE, 1'b1);
    add_beat(1234, 1'b1);                    // single-sample frame
    add_beat(10, 1'b0); add_beat(3, 1'b1);   // first-sample edge
    add_beat(3, 1'b0); add_beat(10, 1'b1);   // last-sample edge
    add_beat(-32768, 1'b0); add_beat(32767, 1'b0); add_beat(-32768, 1'b1);
    // plateau at full swing: largest height correction
    add_beat(-32768, 1'b0); add_beat(32767, 1'b0); add_beat(32767, 1'b0);
    add_beat(-32768, 1'b1);
    // position ties, positive and negative offset
    add_beat(0, 1'b0); add_beat(257, 1'b0); add_beat(2, 1'b1);
    add_beat(2, 1'b0); add_beat(257, 1'b0); add_beat(0, 1'b1);
    // height correction tie
    add_beat(0, 1'b0); add_beat(129, 1'b0); add_beat(2, 1'b1);
    // both edges and an interior peak in one frame
    add_beat(50, 1'b0); add_beat(10, 1'b0); add_beat(40, 1'b0); add_beat(20, 1'b0);
    add_beat(60, 1'b1);
    wait_idle();

    // Random frames over all register settings
    run_random(1'b0, 1'b0);
    run_random(1'b1, 1'b0);
    run_random(1'b0, 1'b1);
    run_random(1'b1, 1'b1);

    if (err_cnt == 0 && peak_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
